// ===== hdl/vpb_pkg.sv =====
package vpb_pkg;

   // fixed-point one in Q1.16
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // register reset values
   localparam logic [16:0] EPS_MIN_RESET = 17'd66;
   localparam logic [16:0] EPS_MAX_RESET = 17'd655;

   // register selects on address bit two, byte offsets 0 and 4
   localparam logic REG_EPS_MIN = 1'b0;
   localparam logic REG_EPS_MAX = 1'b1;

   // pipeline layout
   localparam int unsigned DIV_BITS    = 16;
   localparam int unsigned ST_PREP     = 0;
   localparam int unsigned ST_SQUARE   = DIV_BITS + 1;
   localparam int unsigned ST_CUBE     = DIV_BITS + 2;
   localparam int unsigned ST_WEIGHT   = DIV_BITS + 3;
   localparam int unsigned ST_MUL_LIQ  = DIV_BITS + 4;
   localparam int unsigned ST_SUM_LIQ  = DIV_BITS + 5;
   localparam int unsigned ST_MUL_GAS  = DIV_BITS + 6;
   localparam int unsigned ST_SUM_GAS  = DIV_BITS + 7;
   localparam int unsigned NUM_STAGES  = DIV_BITS + 8;

   typedef struct packed {
      logic [16:0]        gas_fraction;
      logic signed [31:0] liq_vel_x;
      logic signed [31:0] liq_vel_y;
      logic signed [31:0] liq_vel_z;
      logic signed [31:0] liq_temp;
      logic signed [31:0] gas_vel_x;
      logic signed [31:0] gas_vel_y;
      logic signed [31:0] gas_vel_z;
      logic signed [31:0] gas_temp;
   } req_type;

   typedef struct packed {
      logic [16:0]        new_gas_fraction;
      logic signed [31:0] new_liq_vel_x;
      logic signed [31:0] new_liq_vel_y;
      logic signed [31:0] new_liq_vel_z;
      logic signed [31:0] new_liq_temp;
      logic signed [31:0] new_gas_vel_x;
      logic signed [31:0] new_gas_vel_y;
      logic signed [31:0] new_gas_vel_z;
      logic signed [31:0] new_gas_temp;
   } rsp_type;

   // everything one cell carries down the pipe
   typedef struct packed {
      logic [16:0]       alpha;
      logic [16:0]       emin;
      logic [16:0]       emax;
      logic [16:0]       span;
      logic              fix1;
      logic              blend1;
      logic              fix2;
      logic              blend2;
      logic [16:0]       rem1;
      logic [16:0]       rem2;
      logic [15:0]       quo1;
      logic [15:0]       quo2;
      logic [31:0]       x2a;
      logic [31:0]       x2b;
      logic [17:0]       ma;
      logic [17:0]       mb;
      logic [49:0]       wa;
      logic [49:0]       wb;
      logic [16:0]       g1;
      logic [16:0]       g2;
      logic [3:0][31:0]  liq;
      logic [3:0][31:0]  gas;
      logic [3:0][49:0]  pa;
      logic [3:0][49:0]  pb;
   } pipe_type;

   // saturate to signed 32 bit
   function automatic logic [31:0] sat32(input logic signed [34:0] v);
      logic [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'h7fffffff;
      end else if (v < -35'sd2147483648) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // round the blended sum back to Q16.16
   function automatic logic [31:0] mix_round(input logic signed [49:0] a,
                                             input logic signed [49:0] b);
      logic signed [50:0] s;
      logic signed [50:0] sh;
      s  = 51'(a) + 51'(b) + 51'sd32768;
      sh = s >>> 16;
      return sat32(sh[34:0]);
   endfunction

   // smoothstep weight from the products, clamped to one
   function automatic logic [16:0] weight_round(input logic [49:0] w);
      logic [50:0] t;
      logic [18:0] g;
      t = 51'(w) + 51'h80000000;
      g = t[50:32];
      return (g > 19'(ONE_Q16)) ? ONE_Q16 : g[16:0];
   endfunction

   // one divider bit: shift in a zero, subtract the span where it fits
   function automatic logic [32:0] div_bit(input logic [16:0] rem,
                                           input logic [15:0] quo,
                                           input logic [16:0] span);
      logic [17:0] r2;
      logic [17:0] d;
      r2 = {rem, 1'b0};
      d  = {1'b0, span};
      if (r2 >= d) begin
         d = r2 - d;
         return {d[16:0], quo[14:0], 1'b1};
      end
      return {r2[16:0], quo[14:0], 1'b0};
   endfunction

   // the work of pipeline stage k
   function automatic pipe_type pipe_step(input int unsigned k, input pipe_type p);
      pipe_type    n;
      logic [16:0] al;
      logic [16:0] f2;
      logic [32:0] da;
      logic [32:0] db;
      n = p;
      if (k == ST_PREP) begin
         // decide both stages up front, the gas fraction seen by stage two is known
         al       = ONE_Q16 - p.alpha;
         n.fix1   = (al <= p.emin);
         n.blend1 = !n.fix1 && (p.emax > p.emin) && (al < p.emax);
         f2       = n.fix1 ? 17'(ONE_Q16 - p.emin) : p.alpha;
         n.fix2   = (f2 <= p.emin);
         n.blend2 = !n.fix2 && (p.emax > p.emin) && (f2 < p.emax);
         n.span   = p.emax - p.emin;
         n.rem1   = al - p.emin;
         n.rem2   = f2 - p.emin;
         n.quo1   = '0;
         n.quo2   = '0;
      end else if (k <= DIV_BITS) begin
         da     = div_bit(p.rem1, p.quo1, p.span);
         db     = div_bit(p.rem2, p.quo2, p.span);
         n.rem1 = da[32:16];
         n.quo1 = da[15:0];
         n.rem2 = db[32:16];
         n.quo2 = db[15:0];
      end else if (k == ST_SQUARE) begin
         n.x2a = 32'(p.quo1) * 32'(p.quo1);
         n.x2b = 32'(p.quo2) * 32'(p.quo2);
         n.ma  = 18'd196608 - {1'b0, p.quo1, 1'b0};
         n.mb  = 18'd196608 - {1'b0, p.quo2, 1'b0};
      end else if (k == ST_CUBE) begin
         n.wa = 50'(p.x2a) * 50'(p.ma);
         n.wb = 50'(p.x2b) * 50'(p.mb);
      end else if (k == ST_WEIGHT) begin
         n.g1 = weight_round(p.wa);
         n.g2 = weight_round(p.wb);
      end else if (k == ST_MUL_LIQ) begin
         for (int i = 0; i < 4; i++) begin
            n.pa[i] = 50'($signed({1'b0, p.g1}) * $signed(p.liq[i]));
            n.pb[i] = 50'($signed({1'b0, 17'(ONE_Q16 - p.g1)}) * $signed(p.gas[i]));
         end
      end else if (k == ST_SUM_LIQ) begin
         for (int i = 0; i < 4; i++) begin
            if (p.fix1) begin
               n.liq[i] = p.gas[i];
            end else if (p.blend1) begin
               n.liq[i] = mix_round(p.pa[i], p.pb[i]);
            end
         end
         if (p.fix1) begin
            n.alpha = ONE_Q16 - p.emin;
         end
      end else if (k == ST_MUL_GAS) begin
         for (int i = 0; i < 4; i++) begin
            n.pa[i] = 50'($signed({1'b0, p.g2}) * $signed(p.gas[i]));
            n.pb[i] = 50'($signed({1'b0, 17'(ONE_Q16 - p.g2)}) * $signed(p.liq[i]));
         end
      end else if (k == ST_SUM_GAS) begin
         for (int i = 0; i < 4; i++) begin
            if (p.fix2) begin
               n.gas[i] = p.liq[i];
            end else if (p.blend2) begin
               n.gas[i] = mix_round(p.pa[i], p.pb[i]);
            end
         end
         if (p.fix2) begin
            n.alpha = p.emin;
         end
      end
      return n;
   endfunction

endpackage

// ===== hdl/vpb_stage.sv =====
module vpb_stage import vpb_pkg::*; #(
   parameter int unsigned STAGE = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  pipe_type in_data,
   output logic     in_take,
   output logic     out_valid,
   output pipe_type out_data,
   input  logic     out_take
);

   logic     valid_ff;
   pipe_type data_ff;

   // a stage takes when empty or when its content moves on
   assign in_take   = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_take) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         data_ff <= pipe_step(STAGE, in_data);
      end
   end

endmodule

// ===== hdl/vanishing_phase_blend_core.sv =====
// channel    | direction | handshake            | payload
// req        | in        | req_valid/req_stall  | req_data (req_type)
// rsp        | out       | rsp_valid/rsp_stall  | rsp_data (rsp_type)
// csr        | in        | psel/penable/pready  | 3-bit byte address, 32-bit data
//
// one cell per cycle while the receiver does not stall
// the band coordinate comes from the 16-stage divider, one bit per stage
// synchronous reset empties the pipe and loads eps_min 66, eps_max 655
// a stall holds only the stages that are full, bubbles close up behind it
module vanishing_phase_blend_core import vpb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned LAST = NUM_STAGES - 1;

   logic [16:0] eps_min_ff, eps_min_in;
   logic [16:0] eps_max_ff, eps_max_in;
   logic [16:0] wr_val;
   logic        csr_write;
   pipe_type    entry;
   logic        st_valid [NUM_STAGES];
   logic        st_take  [NUM_STAGES];
   pipe_type    st_data  [NUM_STAGES];

   // register writes, values above one clamp to one
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign wr_val     = (csr_pwdata[16:0] > ONE_Q16) ? ONE_Q16 : csr_pwdata[16:0];

   always_comb begin
      eps_min_in = eps_min_ff;
      eps_max_in = eps_max_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_EPS_MIN: eps_min_in = wr_val;
            REG_EPS_MAX: eps_max_in = wr_val;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_min_ff <= EPS_MIN_RESET;
         eps_max_ff <= EPS_MAX_RESET;
      end else begin
         eps_min_ff <= eps_min_in;
         eps_max_ff <= eps_max_in;
      end
   end

   // register reads
   always_comb begin
      unique case (csr_paddr[2])
         REG_EPS_MIN: csr_prdata = {15'd0, eps_min_ff};
         REG_EPS_MAX: csr_prdata = {15'd0, eps_max_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // load the incoming cell into the pipe word
   always_comb begin
      entry        = '0;
      entry.alpha  = (req_data.gas_fraction > ONE_Q16) ? ONE_Q16 : req_data.gas_fraction;
      entry.emin   = eps_min_ff;
      entry.emax   = eps_max_ff;
      entry.liq[0] = req_data.liq_vel_x;
      entry.liq[1] = req_data.liq_vel_y;
      entry.liq[2] = req_data.liq_vel_z;
      entry.liq[3] = req_data.liq_temp;
      entry.gas[0] = req_data.gas_vel_x;
      entry.gas[1] = req_data.gas_vel_y;
      entry.gas[2] = req_data.gas_vel_z;
      entry.gas[3] = req_data.gas_temp;
   end

   // pipeline stages
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      logic     v_in;
      pipe_type d_in;
      logic     t_out;
      if (k == 0) begin : g_head
         assign v_in = req_valid;
         assign d_in = entry;
      end else begin : g_body
         assign v_in = st_valid[k-1];
         assign d_in = st_data[k-1];
      end
      if (k == LAST) begin : g_tail
         assign t_out = !rsp_stall;
      end else begin : g_mid
         assign t_out = st_take[k+1];
      end
      vpb_stage #(.STAGE(k)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_in),
         .in_data   (d_in),
         .in_take   (st_take[k]),
         .out_valid (st_valid[k]),
         .out_data  (st_data[k]),
         .out_take  (t_out)
      );
   end

   assign req_stall = !st_take[0];
   assign rsp_valid = st_valid[LAST];

   // result transaction
   always_comb begin
      rsp_data.new_gas_fraction = st_data[LAST].alpha;
      rsp_data.new_liq_vel_x    = st_data[LAST].liq[0];
      rsp_data.new_liq_vel_y    = st_data[LAST].liq[1];
      rsp_data.new_liq_vel_z    = st_data[LAST].liq[2];
      rsp_data.new_liq_temp     = st_data[LAST].liq[3];
      rsp_data.new_gas_vel_x    = st_data[LAST].gas[0];
      rsp_data.new_gas_vel_y    = st_data[LAST].gas[1];
      rsp_data.new_gas_vel_z    = st_data[LAST].gas[2];
      rsp_data.new_gas_temp     = st_data[LAST].gas[3];
   end

   // an empty output stage never holds off the input
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output stage");

   // a write leaves a threshold within one
   a_eps_clamped: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (eps_min_ff <= ONE_Q16) && (eps_max_ff <= ONE_Q16))
      else $error("threshold above one after write");

   // the result fraction never exceeds one
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.new_gas_fraction <= ONE_Q16))
      else $error("result gas fraction above one");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import vpb_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // register indexes, pipe depth and cycle limit
   localparam int IDX_EPS_MIN = 0;
   localparam int IDX_EPS_MAX = 1;
   localparam int PIPE_LATENCY = 24;
   localparam longint CYCLE_LIMIT = 2000000;

   vanishing_phase_blend_core dut (.*);

   always #5 clock = ~clock;

   // predictor copy of the thresholds
   logic [16:0] cur_eps_min = EPS_MIN_RESET;
   logic [16:0] cur_eps_max = EPS_MAX_RESET;

   rsp_type     blended_cells[$];
   int          mismatch_count = 0;
   longint      cycle_count = 0;
   bit          hold_off = 1'b0;
   bit          random_stall_on = 1'b1;
   int          long_stall_left = 0;

   function automatic logic [16:0] clamp_one(input logic [16:0] v);
      return (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

   // smoothstep weight for a fraction inside the band
   function automatic longint smooth_weight(input longint f);
      longint xi, g;
      xi = ((f - cur_eps_min) <<< 16) / (cur_eps_max - cur_eps_min);
      if (xi > 65536) xi = 65536;
      g = longint'((longint'(xi * xi) * (196608 - 2 * xi) + 64'h80000000) >>> 32);
      return (g > 65536) ? 65536 : g;
   endfunction

   function automatic longint blend_value(input longint g, input longint own,
                                          input longint other);
      longint s;
      s = (g * own + (65536 - g) * other + 32768) >>> 16;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
   endfunction

   // one fix-up or blend stage, returns true on a threshold fix-up
   function automatic bit fix_stage(input longint f, inout longint dst[4],
                                    input longint src[4]);
      longint g;
      if (f <= cur_eps_min) begin
         for (int i = 0; i < 4; i++) dst[i] = src[i];
         return 1'b1;
      end
      if (cur_eps_max > cur_eps_min && f < cur_eps_max) begin
         g = smooth_weight(f);
         for (int i = 0; i < 4; i++) dst[i] = blend_value(g, dst[i], src[i]);
      end
      return 1'b0;
   endfunction

   function automatic rsp_type predict_cell(input req_type c);
      longint  alpha;
      longint  liq[4];
      longint  gas[4];
      rsp_type r;
      alpha = clamp_one(c.gas_fraction);
      liq = '{c.liq_vel_x, c.liq_vel_y, c.liq_vel_z, c.liq_temp};
      gas = '{c.gas_vel_x, c.gas_vel_y, c.gas_vel_z, c.gas_temp};
      if (fix_stage(65536 - alpha, liq, gas)) alpha = 65536 - cur_eps_min;
      if (fix_stage(alpha, gas, liq)) alpha = cur_eps_min;
      r.new_gas_fraction = 17'(alpha);
      r.new_liq_vel_x = 32'(liq[0]);
      r.new_liq_vel_y = 32'(liq[1]);
      r.new_liq_vel_z = 32'(liq[2]);
      r.new_liq_temp  = 32'(liq[3]);
      r.new_gas_vel_x = 32'(gas[0]);
      r.new_gas_vel_y = 32'(gas[1]);
      r.new_gas_vel_z = 32'(gas[2]);
      r.new_gas_temp  = 32'(gas[3]);
      return r;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blended_cells.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = blended_cells.pop_front();
            if (want !== rsp_data) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h actual %h", want, rsp_data);
            end
         end
      end
   end

   // receiver stall: short random stalls, a few long ones, a hold-off, or none when random stalls are off
   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (hold_off) rsp_stall <= 1'b1;
      else if (!random_stall_on) rsp_stall <= 1'b0;
      else if (long_stall_left > 0) begin
         rsp_stall <= 1'b1;
         long_stall_left <= long_stall_left - 1;
      end
      else if (r < 20) rsp_stall <= 1'b1;
      else if (r < 22) begin
         rsp_stall <= 1'b1;
         long_stall_left <= $urandom_range(10, 60);
      end
      else rsp_stall <= 1'b0;
   end

   // gap before a transaction, valid drops only when there is a gap
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n > 0) req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // send one cell, valid stays high until accepted and after it for a following cell
   task automatic send_cell(input req_type c, input bit gaps);
      if (gaps) idle_gap();
      req_data  <= c;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      blended_cells.push_back(predict_cell(c));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (blended_cells.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(input int idx, input logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * idx); csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx == IDX_EPS_MIN) cur_eps_min = clamp_one(v[16:0]);
      else cur_eps_max = clamp_one(v[16:0]);
   endtask

   task automatic set_band(input logic [31:0] lo, input logic [31:0] hi);
      wait_drained();
      write_reg(IDX_EPS_MIN, lo);
      write_reg(IDX_EPS_MAX, hi);
   endtask

   function automatic req_type random_cell(input logic [16:0] frac);
      req_type      c;
      logic [287:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      c = raw[$bits(req_type)-1:0];
      c.gas_fraction = frac;
      return c;
   endfunction

   // fraction biased toward both thresholds of both stages
   function automatic logic [16:0] pick_fraction();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return 17'($urandom_range(0, 131071));
         1, 2: return 17'($urandom_range(0, cur_eps_max + 2));
         3, 4: return 17'(65536 - $urandom_range(0, cur_eps_max + 2));
         5: return 17'($urandom_range(cur_eps_min > 0 ? cur_eps_min - 1 : 0,
                                     cur_eps_min + 1));
         6: return 17'(65536 - $urandom_range(cur_eps_min > 0 ? cur_eps_min - 1 : 0,
                                             cur_eps_min + 1));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // extremes of fields and each special case
   task automatic test_directed();
      req_type c;
      logic [16:0] fr[12];
      fr = '{17'd0, 17'd65536, 17'd131071, 17'd65536 - 17'd66, 17'd65536 - 17'd67,
             17'd66, 17'd67, 17'd300, 17'd65536 - 17'd300, 17'd654, 17'd655, 17'd32768};
      foreach (fr[i]) begin
         c = random_cell(fr[i]);
         if (i % 3 == 0) begin
            c.liq_vel_x = 32'h7fffffff; c.gas_vel_x = 32'h80000000;
            c.liq_temp = 32'h80000000;  c.gas_temp = 32'h7fffffff;
         end
         send_cell(c, 1'b0);
      end
      c = '0; send_cell(c, 1'b0);
      c = '1; send_cell(c, 1'b0);
      // register above one and empty band
      set_band(32'h1ffff, 32'h1ffff);
      send_cell(random_cell(17'd65536), 1'b0);
      send_cell(random_cell(17'd0), 1'b0);
      set_band(32'd800, 32'd100);
      send_cell(random_cell(17'd500), 1'b0);
      send_cell(random_cell(17'd65536 - 17'd500), 1'b0);
      // stage two always fires when eps_min is above one half
      set_band(32'd40000, 32'd50000);
      send_cell(random_cell(17'd0), 1'b0);
      send_cell(random_cell(17'd65536), 1'b0);
      send_cell(random_cell(17'd30000), 1'b0);
   endtask

   task automatic test_random_bands();
      int lo, hi;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin lo = 66; hi = 655; end
            1: begin lo = 0; hi = 65536; end
            2: begin lo = 0; hi = 0; end
            3: begin lo = 65536; hi = 0; end
            default: begin
               lo = $urandom_range(0, 40000);
               hi = lo + $urandom_range(1, 30000);
            end
         endcase
         set_band(lo, hi);
         for (int i = 0; i < 100; i++) send_cell(random_cell(pick_fraction()), 1'b1);
      end
   endtask

   // hold the receiver off while cells keep coming, pipe fills and stalls
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 60; i++) send_cell(random_cell(pick_fraction()), 1'b0);
      join
   endtask

   task automatic test_full_rate();
      random_stall_on = 1'b0;
      for (int i = 0; i < 60; i++) send_cell(random_cell(pick_fraction()), 1'b0);
      wait_drained();
      random_stall_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_bands();
      test_backpressure();
      test_full_rate();
      wait_drained();
      if (mismatch_count == 0 && blended_cells.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
